// File: src/signed_word_sorter_defines.svh
// Assertion macros used by the sorter RTL.
`ifndef SIGNED_WORD_SORTER_DEFINES_SVH
`define SIGNED_WORD_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sws_pkg.sv
// Package: beat types and defaults for the signed word sorter.
package sws_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;

    // Input beat
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     last;
    } sws_in_t;

    // Result beat
    typedef struct packed {
        logic signed [WORD_W-1:0] sorted_value;
        logic                     final_res;
        logic                     overflowed;
    } sws_out_t;

endpackage

// File: src/sws_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module sws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/signed_word_sorter.sv
// Top level: collects a list of signed words and returns it in ascending order.
//
// Usage:
//   Input channel: drive item (value, last) with start high; the beat is taken
//   at a rising edge where start is high and busy is low. While loading, busy
//   stays low. Words past DEPTH are dropped and every result of that list
//   then has overflowed set.
//   The beat with last set starts the sort: busy rises and the list (n words)
//   is sorted by an exchange sort over the word RAM. Row i keeps the
//   running minimum in a pivot register and scans entries i+1..n-1, one RAM
//   read and at most one swap write per cycle; at the end of each row the
//   minimum is emitted, so results come out in ascending order during the sort.
//   Each row reads entry i through the registered RAM read port (RD_PIV,
//   GET_PIV) and then scans (SCAN); the last row has no scan. The next list
//   may start on the cycle the final result is shown.
//   Results: strobe is high for exactly one cycle per result; final_res marks
//   the largest word. The receiver cannot stall. Reset clears the word count,
//   the overflow flag and the controller; RAM contents are not cleared.
`include "signed_word_sorter_defines.svh"

module signed_word_sorter
    import sws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  sws_in_t  item,
    output logic     busy,
    output logic     strobe,
    output sws_out_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        IDLE,
        RD_PIV,
        GET_PIV,
        SCAN
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     drop_reg, drop_next;
    logic [AW-1:0]            i_reg, i_next;
    logic [AW-1:0]            j_reg, j_next;
    logic signed [WORD_W-1:0] piv_reg, piv_next;
    logic                     strobe_reg, strobe_next;
    sws_out_t                 result_reg, result_next;

    // RAM ports
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [WORD_W-1:0]        wdata;
    logic [AW-1:0]            raddr;
    logic [WORD_W-1:0]        rdata;
    logic signed [WORD_W-1:0] rd_word;

    logic [CW-1:0]            i_plus1;
    logic [CW-1:0]            j_plus1;
    logic                     swap;
    logic signed [WORD_W-1:0] piv_low;

    sws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_word = $signed(rdata);
    assign i_plus1 = CW'(i_reg) + CW'(1);
    assign j_plus1 = CW'(j_reg) + CW'(1);
    assign swap    = piv_reg > rd_word;
    assign piv_low = swap ? rd_word : piv_reg;

    // Next-state, RAM control and result selection
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        piv_next    = piv_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = j_reg;
        wdata       = piv_reg;
        raddr       = i_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    if (cnt_reg < CW'(DEPTH))
                    begin
                        we       = 1'b1;
                        waddr    = cnt_reg[AW-1:0];
                        wdata    = item.value;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        i_next     = '0;
                        state_next = RD_PIV;
                    end
                end
            end
            RD_PIV:
            begin
                raddr      = i_reg;
                state_next = GET_PIV;
            end
            GET_PIV:
            begin
                piv_next = rd_word;
                if (i_plus1 < cnt_reg)
                begin
                    raddr      = i_plus1[AW-1:0];
                    j_next     = i_plus1[AW-1:0];
                    state_next = SCAN;
                end
                else
                begin
                    // last row: the remaining word is the largest
                    strobe_next              = 1'b1;
                    result_next.sorted_value = rd_word;
                    result_next.final_res    = 1'b1;
                    result_next.overflowed   = drop_reg;
                    cnt_next                 = '0;
                    drop_next                = 1'b0;
                    state_next               = IDLE;
                end
            end
            SCAN:
            begin
                // swap out of order pair: larger pivot goes to entry j
                if (swap)
                begin
                    we    = 1'b1;
                    waddr = j_reg;
                    wdata = piv_reg;
                end
                piv_next = piv_low;
                if (j_plus1 < cnt_reg)
                begin
                    raddr  = j_plus1[AW-1:0];
                    j_next = j_plus1[AW-1:0];
                end
                else
                begin
                    // row done: pivot is the minimum of the rest
                    strobe_next              = 1'b1;
                    result_next.sorted_value = piv_low;
                    result_next.final_res    = 1'b0;
                    result_next.overflowed   = drop_reg;
                    i_next                   = i_plus1[AW-1:0];
                    state_next               = RD_PIV;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            cnt_reg    <= '0;
            drop_reg   <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            piv_reg    <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            piv_reg    <= piv_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

    assign busy   = state_reg != IDLE;
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Checks
    `SWS_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= CW'(DEPTH),
        "word count beyond capacity")
    `SWS_ASSERT_NOW(a_final_clears, strobe_reg && result_reg.final_res,
        cnt_reg == '0 && !drop_reg && state_reg == IDLE,
        "list state not cleared after final result")
    `SWS_ASSERT_NOW(a_mid_busy, strobe_reg && !result_reg.final_res, busy,
        "sorter idle after a non-final result")
    `SWS_ASSERT_NOW(a_scan_bounds, state_reg == SCAN,
        j_reg > i_reg && CW'(j_reg) < cnt_reg, "scan index out of row")
    `SWS_ASSERT_NOW(a_no_collide, state_reg == SCAN && we, waddr != raddr,
        "swap write and read hit the same entry")

endmodule
